/* hdl/drrip_pkg.sv */
// Shared constants and types for the DRRIP replacement block.
`timescale 1ns / 1ps
`default_nettype none

package drrip_pkg;

  // Geometry. NumSets and the leader period are powers of two.
  localparam int NumSets      = 2048;
  localparam int NumWays      = 16;
  localparam int PredW        = 2;
  localparam int SelW         = 10;
  localparam int LeaderGroups = 32;

  localparam int SetW         = $clog2(NumSets);
  localparam int WayIdxW      = $clog2(NumWays);
  localparam int LeaderPeriod = (NumSets / LeaderGroups == 0) ? 1 : NumSets / LeaderGroups;

  localparam logic [PredW-1:0] PredMax = {PredW{1'b1}};
  localparam logic [SelW-1:0]  SelMax  = {SelW{1'b1}};
  localparam logic [SelW-1:0]  SelInit = SelMax >> 1;
  localparam logic [4:0]       PcMask  = 5'h1F;

  // Command codes.
  localparam logic CmdFind   = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  // Input word.
  typedef struct packed {
    logic       command;
    logic [10:0] set_index;
    logic [3:0] way_index;
    logic       was_hit;
    logic [4:0] pc_low_bits;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [3:0] victim_way;
    logic [9:0] selector_value;
  } rsp_t;

  // One memory row holds the whole set.
  typedef struct packed {
    logic [NumWays-1:0]            valid;
    logic [NumWays-1:0][PredW-1:0] rrpv;
  } row_t;

  localparam int RowW = $bits(row_t);

  // Row written back to every set by the clearing pass.
  localparam row_t RowReset = '{valid: '0, rrpv: {NumWays{PredMax}}};

  // Outcome of one row computation.
  typedef struct packed {
    row_t                row;
    logic [WayIdxW-1:0]  victim;
    logic [SelW-1:0]     sel;
  } calc_t;

endpackage

`default_nettype wire

/* hdl/drrip_cache_replacement.sv */
// Top level of the DRRIP replacement block: sequencer, set-row memory and selector.
// An accepted word and its set row are registered; the compute state then writes the row back
// and registers the result word with its done strobe.
// A new word is taken only in the idle state, never while a row is computed and written back.
// After reset a clearing pass writes every one of the NumSets rows, busy held high.
// The selector resets to its midpoint; the receiver cannot stall, each result shows one cycle.
`timescale 1ns / 1ps
`default_nettype none

module drrip_cache_replacement
  import drrip_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output rsp_t      rsp_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StCalc
  } state_e;

  state_e          state_q;
  logic [SetW-1:0] clr_q;
  req_t            req_q;
  logic [SelW-1:0] sel_q;
  logic            done_q;
  rsp_t            rsp_q;

  logic            accept;
  logic            ram_we;
  logic [SetW-1:0] ram_addr;
  logic [RowW-1:0] ram_wdata;
  logic [RowW-1:0] ram_rdata;
  calc_t           calc;

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q != StIdle);

  // Row memory port: clearing writes, read at acceptance, write-back in the compute cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = SetW'(req_i.set_index);
    ram_wdata = calc.row;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = RowReset;
      end
      StCalc: begin
        ram_we   = 1'b1;
        ram_addr = SetW'(req_q.set_index);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  drrip_ram #(
    .Width(RowW),
    .Depth(NumSets)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  drrip_row u_row (
    .row_i (ram_rdata),
    .req_i (req_q),
    .sel_i (sel_q),
    .calc_o(calc)
  );

  // Sequencer with the registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      req_q   <= '0;
      sel_q   <= SelInit;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SetW'(NumSets - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (accept) begin
            req_q   <= req_i;
            state_q <= StCalc;
          end
        end
        StCalc: begin
          sel_q                <= calc.sel;
          rsp_q.victim_way     <= 4'(calc.victim);
          rsp_q.selector_value <= 10'(calc.sel);
          done_q               <= 1'b1;
          state_q              <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // An accepted word always raises its result strobe once the compute state is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing after accepted word");

  // Results never come in adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result strobes");

  // The selector moves by at most one per word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != $past(sel_q)) |->
      ((sel_q - $past(sel_q)) == SelW'(1) || ($past(sel_q) - sel_q) == SelW'(1)))
    else $error("selector jumped by more than one");

  // Find results always report the selector unchanged from the previous word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc && req_q.command == CmdFind) |=> (sel_q == $past(sel_q)))
    else $error("selector changed on a find command");

endmodule

`default_nettype wire

/* hdl/drrip_ram.sv */
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module drrip_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write when enabled; the read port always captures the addressed row.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/drrip_row.sv */
// Victim search, aging, promotion, insertion and selector update for one set row.
`timescale 1ns / 1ps
`default_nettype none

module drrip_row
  import drrip_pkg::*;
(
  input  wire logic            [RowW-1:0] row_i,
  input  wire req_t                       req_i,
  input  wire logic            [SelW-1:0] sel_i,
  output calc_t                           calc_o
);

  row_t               row;
  logic               any_inv;
  logic [WayIdxW-1:0] first_inv;
  logic [PredW-1:0]   top;
  logic [PredW-1:0]   add;
  logic               hit_found;
  logic [WayIdxW-1:0] top_way;
  logic [SetW-1:0]    set_mod;
  logic               sr_leader;
  logic               br_leader;
  logic               near_policy;
  logic [PredW-1:0]   ins;
  logic               way_ok;
  logic [WayIdxW-1:0] way;

  assign row = row_t'(row_i);
  assign way = WayIdxW'(req_i.way_index);
  assign way_ok = (32'(req_i.way_index) < NumWays);

  // Set dueling: position of the set inside its leader period.
  assign set_mod   = SetW'(req_i.set_index) % SetW'(LeaderPeriod);
  assign sr_leader = (set_mod == '0);
  assign br_leader = !sr_leader && (set_mod == SetW'(LeaderPeriod / 2));

  // Scan the row: first invalid way, largest prediction, first way at it.
  always_comb begin
    any_inv   = 1'b0;
    first_inv = '0;
    top       = '0;
    hit_found = 1'b0;
    top_way   = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (!row.valid[w] && !any_inv) begin
        any_inv   = 1'b1;
        first_inv = WayIdxW'(w);
      end
      if (row.rrpv[w] > top) begin
        top = row.rrpv[w];
      end
    end
    for (int w = 0; w < NumWays; w++) begin
      if (!hit_found && row.rrpv[w] == top) begin
        hit_found = 1'b1;
        top_way   = WayIdxW'(w);
      end
    end
    add = PredMax - top;
  end

  // Build the new row, the victim and the next selector value.
  always_comb begin
    calc_o.row    = row;
    calc_o.victim = '0;
    calc_o.sel    = sel_i;
    near_policy   = 1'b1;
    ins           = '0;
    if (req_i.command == CmdFind) begin
      if (any_inv) begin
        calc_o.victim = first_inv;
      end else begin
        calc_o.victim = top_way;
        for (int w = 0; w < NumWays; w++) begin
          calc_o.row.rrpv[w] = row.rrpv[w] + add;
        end
      end
    end else begin
      if (!req_i.was_hit) begin
        // Leaders train the saturating selector.
        if (sr_leader) begin
          if (sel_i != '0) begin
            calc_o.sel = sel_i - 1'b1;
          end
        end else if (br_leader) begin
          if (sel_i != SelMax) begin
            calc_o.sel = sel_i + 1'b1;
          end
        end
        if (sr_leader) begin
          near_policy = 1'b1;
        end else if (br_leader) begin
          near_policy = 1'b0;
        end else begin
          near_policy = (calc_o.sel >= SelInit);
        end
        // Near insertion for SRRIP, and for BRRIP when the low PC bits are zero.
        if (near_policy || (req_i.pc_low_bits & PcMask) == '0) begin
          ins = PredMax - 1'b1;
        end else begin
          ins = PredMax;
        end
      end
      if (way_ok) begin
        calc_o.row.valid[way] = 1'b1;
        calc_o.row.rrpv[way]  = ins;
      end
    end
  end

endmodule

`default_nettype wire
